>>> src/efd_pkg.sv
// Shared widths, constants and the arctangent table of the fisheye
// distortion map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efd_pkg;

  // Datapath widths.
  localparam int unsigned D_W    = 26;  // pixel offset from centre, Q.8
  localparam int unsigned FOC_W  = 24;
  localparam int unsigned CEN_W  = 25;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned QN_W   = 49;  // normalised magnitude, Q.24
  localparam int unsigned AB_W   = 31;
  localparam int unsigned SH_W   = 5;
  localparam int unsigned SQN_W  = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned R_W    = 50;
  localparam int unsigned XY_W   = 53;
  localparam int unsigned Z_W    = 34;
  localparam int unsigned TH_W   = 25;
  localparam int unsigned THD_W  = 36;
  localparam int unsigned QS_W   = 37;
  localparam int unsigned SC_W   = 39;
  localparam int unsigned OUT_W  = 25;

  typedef logic signed [D_W-1:0] diff_t;

  localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [SC_W-1:0] ONE_Q30     = 39'sd1073741824;
  localparam logic [QS_W-1:0]        S_LIMIT     = {QS_W{1'b1}};
  localparam logic signed [63:0]     OUT_MAX64   = 64'sd16777215;
  localparam logic signed [63:0]     OUT_MIN64   = -64'sd16777216;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_COEF_THETA2,
    REG_COEF_THETA4,
    REG_COEF_THETA6,
    REG_COEF_THETA8
  } reg_idx_e;

  // Arctangent of 2^-i in Q2.30, truncated toward zero up to index 26 and rounded beyond it.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h3243F6A8;
      5'd1:  val = 32'h1DAC6705;
      5'd2:  val = 32'h0FADBAFC;
      5'd3:  val = 32'h07F56EA6;
      5'd4:  val = 32'h03FEAB76;
      5'd5:  val = 32'h01FFD55B;
      5'd6:  val = 32'h00FFFAAA;
      5'd7:  val = 32'h007FFF55;
      5'd8:  val = 32'h003FFFEA;
      5'd9:  val = 32'h001FFFFD;
      5'd10: val = 32'h000FFFFF;
      5'd11: val = 32'h0007FFFF;
      5'd12: val = 32'h0003FFFF;
      5'd13: val = 32'h0001FFFF;
      5'd14: val = 32'h0000FFFF;
      5'd15: val = 32'h00007FFF;
      5'd16: val = 32'h00003FFF;
      5'd17: val = 32'h00001FFF;
      5'd18: val = 32'h00000FFF;
      5'd19: val = 32'h000007FF;
      5'd20: val = 32'h000003FF;
      5'd21: val = 32'h000001FF;
      5'd22: val = 32'h000000FF;
      5'd23: val = 32'h0000007F;
      5'd24: val = 32'h0000003F;
      5'd25: val = 32'h0000001F;
      5'd26: val = 32'h0000000F;
      5'd27: val = 32'h00000008;
      5'd28: val = 32'h00000004;
      5'd29: val = 32'h00000002;
      5'd30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> src/efd_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Stand-alone; the caller supplies a starting remainder below the divisor.
`timescale 1ns / 1ps
`default_nettype none

module efd_div_pipe #(
  parameter int unsigned DEN_W  = 24,
  parameter int unsigned QUO_W  = 49,
  parameter int unsigned SIDE_W = 26
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [QUO_W-1:0]  low_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [QUO_W-1:0]  vld_q;
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  work_q [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  // Valid bits move with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0]  rem_in;
    logic [QUO_W-1:0]  work_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    cur;
    logic [DEN_W:0]    diff;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign work_in = low_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign work_in = work_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down the next dividend bit and try the subtraction.
    assign cur  = {rem_in, work_in[QUO_W-1]};
    assign diff = cur - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= {1'b0, den_in}) begin
          rem_q[k]  <= diff[DEN_W-1:0];
          work_q[k] <= {work_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[DEN_W-1:0];
          work_q[k] <= {work_in[QUO_W-2:0], 1'b0};
        end
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = work_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

`default_nettype wire

>>> src/efd_isqrt_pipe.sv
// Pipelined integer square root of a 64-bit word, one root bit per stage.
// Stand-alone; the result is the floor of the square root.
`timescale 1ns / 1ps
`default_nettype none

module efd_isqrt_pipe #(
  parameter int unsigned SIDE_W = 57
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       n_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned STAGES = 32;

  logic [STAGES-1:0] vld_q;
  logic [63:0]       n_q    [STAGES];
  logic [35:0]       rem_q  [STAGES];
  logic [31:0]       root_q [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [63:0]       n_in;
    logic [35:0]       rem_in;
    logic [31:0]       root_in;
    logic [SIDE_W-1:0] side_in;
    logic [35:0]       cur;
    logic [35:0]       trial;

    if (k == 0) begin : g_first
      assign n_in    = n_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Take the next bit pair and test root*4+1 against the remainder.
    assign cur   = {rem_in[33:0], n_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          rem_q[k]  <= cur - trial;
          root_q[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[k]  <= cur;
          root_q[k] <= {root_in[30:0], 1'b0};
        end
        n_q[k]    <= {n_in[61:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign root_o  = root_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

`default_nettype wire

>>> src/efd_cordic_pipe.sv
// Pipelined circular CORDIC in vectoring mode: the angle of (1.0, r).
// Depends on efd_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module efd_cordic_pipe import efd_pkg::*; #(
  parameter int unsigned ITER   = 24,
  parameter int unsigned SIDE_W = 102
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [R_W-1:0]        y_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic signed [Z_W-1:0] z_o,
  output logic [SIDE_W-1:0]     side_o
);

  logic [ITER-1:0]        vld_q;
  logic signed [XY_W-1:0] x_q    [ITER];
  logic signed [XY_W-1:0] y_q    [ITER];
  logic signed [Z_W-1:0]  z_q    [ITER];
  logic [SIDE_W-1:0]      side_q [ITER];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ITER-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < ITER; k++) begin : g_stage
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic [SIDE_W-1:0]      side_in;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  ang;

    if (k == 0) begin : g_first
      assign x_in    = XY_W'(64'sd16777216);
      assign y_in    = $signed({{(XY_W-R_W){1'b0}}, y_i});
      assign z_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign y_in    = y_q[k-1];
      assign z_in    = z_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign xs  = x_in >>> k;
    assign ys  = y_in >>> k;
    assign ang = $signed({{(Z_W-32){1'b0}}, atan_q30(5'(k))});

    // Rotate toward the x axis and accumulate the angle.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_in > 0) begin
          x_q[k] <= x_in + ys;
          y_q[k] <= y_in - xs;
          z_q[k] <= z_in + ang;
        end else begin
          x_q[k] <= x_in - ys;
          y_q[k] <= y_in + xs;
          z_q[k] <= z_in - ang;
        end
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ITER-1];
  assign z_o     = z_q[ITER-1];
  assign side_o  = side_q[ITER-1];

endmodule

`default_nettype wire

>>> src/efd_poly.sv
// Distortion polynomial: powers of theta, weighted sum and thetad, seven
// register stages. Depends on efd_pkg for widths and constants.
`timescale 1ns / 1ps
`default_nettype none

module efd_poly import efd_pkg::*; #(
  parameter int unsigned SIDE_W = 102
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [TH_W-1:0]          th_i,
  input  logic signed [COEF_W-1:0] coef2_i,
  input  logic signed [COEF_W-1:0] coef4_i,
  input  logic signed [COEF_W-1:0] coef6_i,
  input  logic signed [COEF_W-1:0] coef8_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic signed [THD_W-1:0]  thd_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int unsigned STAGES = 7;

  logic [STAGES-1:0] vld_q;
  logic [SIDE_W-1:0] side_q [STAGES];
  logic [TH_W-1:0]   th_q   [STAGES-2];

  logic [25:0] t2_q1, t2_q2, t2_q3;
  logic [26:0] t4_q2, t4_q3;
  logic [27:0] t6_q3;
  logic [29:0] t8_q3;
  logic signed [63:0] m2_q, m4_q, m6_q, m8_q;
  logic signed [39:0] poly_q;
  logic signed [45:0] ph_q;
  logic [44:0]        pl_q;
  logic signed [THD_W-1:0] thd_q;

  logic [49:0] sq_th;
  logic [51:0] sq_t2;
  logic [52:0] p_t6;
  logic [53:0] p_t8;
  logic signed [63:0] acc;
  logic signed [63:0] acc_sh;
  logic signed [65:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  // Sideband and theta travel alongside the arithmetic.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      th_q[0]   <= th_i;
      for (int k = 1; k < STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int k = 1; k < STAGES - 2; k++) begin
        th_q[k] <= th_q[k-1];
      end
    end
  end

  // Powers of theta, each product floored back to Q.24.
  assign sq_th = th_i * th_i;
  assign sq_t2 = t2_q1 * t2_q1;
  assign p_t6  = t4_q2 * t2_q2;
  assign p_t8  = t4_q2 * t4_q2;

  // Weighted sum and the Q.30 polynomial value.
  assign acc    = m2_q + m4_q + m6_q + m8_q;
  assign acc_sh = acc >>> 24;

  // Recombine the two partial products of theta times the polynomial.
  assign prod = ($signed({{20{ph_q[45]}}, ph_q}) <<< 20) + $signed({21'b0, pl_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q1  <= sq_th[49:24];
      t4_q2  <= sq_t2[50:24];
      t2_q2  <= t2_q1;
      t6_q3  <= p_t6[51:24];
      t8_q3  <= p_t8[53:24];
      t2_q3  <= t2_q2;
      t4_q3  <= t4_q2;
      m2_q   <= coef2_i * $signed({1'b0, t2_q3});
      m4_q   <= coef4_i * $signed({1'b0, t4_q3});
      m6_q   <= coef6_i * $signed({1'b0, t6_q3});
      m8_q   <= coef8_i * $signed({1'b0, t8_q3});
      poly_q <= 40'sd1073741824 + acc_sh[39:0];
      ph_q   <= $signed({1'b0, th_q[4]}) * $signed(poly_q[39:20]);
      pl_q   <= th_q[4] * poly_q[19:0];
      thd_q  <= prod[65:30];
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign thd_o   = thd_q;
  assign side_o  = side_q[STAGES-1];

endmodule

`default_nettype wire

>>> src/equidistant_fisheye_distortion_map.sv
// Equidistant fisheye distortion map, top level: configuration registers,
// the glue stages and the pipeline units. Depends on efd_pkg and all efd_ units.
//
// Use: one word on the input channel (in_valid_i / in_ready_o) carries an
// integer pixel column and row. One word on the output channel
// (out_valid_o / out_ready_i) returns the distorted source position in
// signed Q16.8 and a flag that is set when either coordinate clipped.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i with no wait; an index of eight or above is ignored. Write
// them only while no word is in flight.
// Throughput is one word per cycle while the receiver keeps up. The pipeline
// has 49 divider stages for normalisation, 32 square root stages, one CORDIC
// stage per iteration, seven polynomial stages, 37 divider stages for the
// scale and ten glue stages.
// Reset clears every valid bit and loads the register reset values.
// When the receiver stalls, the whole pipeline holds in place; in_ready_o
// is high whenever the output register is empty or being taken.
`timescale 1ns / 1ps
`default_nettype none

module equidistant_fisheye_distortion_map import efd_pkg::*; #(
  parameter int unsigned COORD_BITS      = 12,
  parameter int unsigned ATAN_ITERATIONS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_W-1:0]       cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [COORD_BITS-1:0]   pixel_column_i,
  input  logic [COORD_BITS-1:0]   pixel_row_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] source_x_o,
  output logic signed [OUT_W-1:0] source_y_o,
  output logic                    saturated_o
);

  localparam int unsigned SQ_SIDE_W = SH_W + 2 * D_W;
  localparam int unsigned CO_SIDE_W = R_W + 2 * D_W;
  localparam int unsigned DV_SIDE_W = 2 * D_W + 3;

  // Configuration registers.
  logic [FOC_W-1:0]         focal_x_q, focal_y_q;
  logic signed [CEN_W-1:0]  center_x_q, center_y_q;
  logic signed [COEF_W-1:0] coef2_q, coef4_q, coef6_q, coef8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 24'd131072;
      focal_y_q  <= 24'd131072;
      center_x_q <= 25'sd81920;
      center_y_q <= 25'sd61440;
      coef2_q    <= '0;
      coef4_q    <= '0;
      coef6_q    <= '0;
      coef8_q    <= '0;
    end else if (cfg_we_i && !cfg_index_i[IDX_W-1]) begin
      case (reg_idx_e'(cfg_index_i[2:0]))
        REG_FOCAL_X:     focal_x_q  <= cfg_data_i[FOC_W-1:0];
        REG_FOCAL_Y:     focal_y_q  <= cfg_data_i[FOC_W-1:0];
        REG_CENTER_X:    center_x_q <= $signed(cfg_data_i[CEN_W-1:0]);
        REG_CENTER_Y:    center_y_q <= $signed(cfg_data_i[CEN_W-1:0]);
        REG_COEF_THETA2: coef2_q    <= $signed(cfg_data_i);
        REG_COEF_THETA4: coef4_q    <= $signed(cfg_data_i);
        REG_COEF_THETA6: coef6_q    <= $signed(cfg_data_i);
        REG_COEF_THETA8: coef8_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // One enable for the whole pipeline: advance unless the output is stuck.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Valid bits of the glue stages.
  logic v0_q, vsh_q, vsq_q, vsm_q, vr_q, vth_q, vdv_q, vsc_q, vml_q;
  logic divx_valid, divy_valid, sqrt_valid, cor_valid, poly_valid, dv2_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      vsh_q       <= 1'b0;
      vsq_q       <= 1'b0;
      vsm_q       <= 1'b0;
      vr_q        <= 1'b0;
      vth_q       <= 1'b0;
      vdv_q       <= 1'b0;
      vsc_q       <= 1'b0;
      vml_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= in_valid_i;
      vsh_q       <= divx_valid && divy_valid;
      vsq_q       <= vsh_q;
      vsm_q       <= vsq_q;
      vr_q        <= sqrt_valid;
      vth_q       <= cor_valid;
      vdv_q       <= poly_valid;
      vsc_q       <= dv2_valid;
      vml_q       <= vsc_q;
      out_valid_q <= vml_q;
    end
  end

  // Offsets from the principal point in Q.8.
  diff_t dx_q, dy_q;
  diff_t px, py;
  assign px = diff_t'({pixel_column_i, 8'b0});
  assign py = diff_t'({pixel_row_i, 8'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= px - diff_t'(center_x_q);
      dy_q <= py - diff_t'(center_y_q);
    end
  end

  // Normalisation by the focal lengths; a zero focal length acts as one.
  diff_t mag_x, mag_y;
  logic [FOC_W-1:0] den_x, den_y;
  logic [QN_W-1:0]  quo_x, quo_y;
  diff_t dx_dv1, dy_dv1;

  assign mag_x = dx_q[D_W-1] ? -dx_q : dx_q;
  assign mag_y = dy_q[D_W-1] ? -dy_q : dy_q;
  assign den_x = (focal_x_q == '0) ? FOC_W'(1) : focal_x_q;
  assign den_y = (focal_y_q == '0) ? FOC_W'(1) : focal_y_q;

  efd_div_pipe #(.DEN_W(FOC_W), .QUO_W(QN_W), .SIDE_W(D_W)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .rem_i   ('0),
    .low_i   ({mag_x[24:0], 24'b0}),
    .den_i   (den_x),
    .side_i  (dx_q),
    .valid_o (divx_valid),
    .quo_o   (quo_x),
    .side_o  (dx_dv1)
  );

  efd_div_pipe #(.DEN_W(FOC_W), .QUO_W(QN_W), .SIDE_W(D_W)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .rem_i   ('0),
    .low_i   ({mag_y[24:0], 24'b0}),
    .den_i   (den_y),
    .side_i  (dy_q),
    .valid_o (divy_valid),
    .quo_o   (quo_y),
    .side_o  (dy_dv1)
  );

  // Shift both magnitudes down until each fits in 31 bits.
  logic [17:0]     or_hi;
  logic [SH_W-1:0] sh;
  assign or_hi = quo_x[QN_W-1:AB_W] | quo_y[QN_W-1:AB_W];

  always_comb begin
    sh = '0;
    for (int j = 0; j < 18; j++) begin
      if (or_hi[j]) begin
        sh = SH_W'(j + 1);
      end
    end
  end

  logic [AB_W-1:0]  a_q, b_q;
  logic [SH_W-1:0]  s_sh_q, s_sq_q, s_sm_q;
  diff_t            dx_sh_q, dy_sh_q, dx_sq_q, dy_sq_q, dx_sm_q, dy_sm_q;
  logic [61:0]      aa_q, bb_q;
  logic [SQN_W-1:0] n_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= AB_W'(quo_x >> sh);
      b_q     <= AB_W'(quo_y >> sh);
      s_sh_q  <= sh;
      dx_sh_q <= dx_dv1;
      dy_sh_q <= dy_dv1;
      aa_q    <= a_q * a_q;
      bb_q    <= b_q * b_q;
      s_sq_q  <= s_sh_q;
      dx_sq_q <= dx_sh_q;
      dy_sq_q <= dy_sh_q;
      n_q     <= SQN_W'(aa_q) + SQN_W'(bb_q);
      s_sm_q  <= s_sq_q;
      dx_sm_q <= dx_sq_q;
      dy_sm_q <= dy_sq_q;
    end
  end

  // Radius.
  logic [ROOT_W-1:0]    root;
  logic [SQ_SIDE_W-1:0] sq_side;
  logic [SH_W-1:0]      s_rt;
  diff_t                dx_rt, dy_rt;

  efd_isqrt_pipe #(.SIDE_W(SQ_SIDE_W)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vsm_q),
    .n_i     (n_q),
    .side_i  ({s_sm_q, dx_sm_q, dy_sm_q}),
    .valid_o (sqrt_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  assign {s_rt, dx_rt, dy_rt} = sq_side;

  logic [R_W-1:0] r_q;
  diff_t          dx_r_q, dy_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q    <= R_W'(root) << s_rt;
      dx_r_q <= dx_rt;
      dy_r_q <= dy_rt;
    end
  end

  // Angle of incidence.
  logic signed [Z_W-1:0] z;
  logic [CO_SIDE_W-1:0]  co_side;

  efd_cordic_pipe #(.ITER(ATAN_ITERATIONS), .SIDE_W(CO_SIDE_W)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vr_q),
    .y_i     (r_q),
    .side_i  ({r_q, dx_r_q, dy_r_q}),
    .valid_o (cor_valid),
    .z_o     (z),
    .side_o  (co_side)
  );

  // Clamp the angle to a quarter turn and drop to Q.24.
  logic signed [Z_W-1:0] zc;
  logic [TH_W-1:0]       th_q;
  logic [CO_SIDE_W-1:0]  th_side_q;

  always_comb begin
    zc = z;
    if (z < 0) begin
      zc = '0;
    end else if (z > HALF_PI_Q30) begin
      zc = HALF_PI_Q30;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      th_q      <= zc[30:6];
      th_side_q <= co_side;
    end
  end

  // Distorted angle.
  logic signed [THD_W-1:0] thd;
  logic [CO_SIDE_W-1:0]    poly_side;

  efd_poly #(.SIDE_W(CO_SIDE_W)) u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vth_q),
    .th_i    (th_q),
    .coef2_i (coef2_q),
    .coef4_i (coef4_q),
    .coef6_i (coef6_q),
    .coef8_i (coef8_q),
    .side_i  (th_side_q),
    .valid_o (poly_valid),
    .thd_o   (thd),
    .side_o  (poly_side)
  );

  // Scale division set-up. A quotient at or above 2^37 is detected here,
  // so the divider only forms the low 37 bits.
  logic [R_W-1:0]   r_p;
  diff_t            dx_p, dy_p;
  logic [THD_W-1:0] thd_abs;
  logic [25:0]      num_hi;
  logic             sat_p;

  assign {r_p, dx_p, dy_p} = poly_side;
  assign thd_abs = thd[THD_W-1] ? THD_W'(-thd) : THD_W'(thd);
  assign num_hi  = thd_abs[32:7];
  assign sat_p   = {{(R_W-26){1'b0}}, num_hi} >= r_p;

  logic [R_W-1:0]  dv_rem_q, dv_r_q;
  logic [QS_W-1:0] dv_low_q;
  logic            dv_neg_q, dv_sat_q, dv_zero_q;
  diff_t           dx_dv_q, dy_dv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q  <= sat_p ? '0 : {{(R_W-26){1'b0}}, num_hi};
      dv_low_q  <= {thd_abs[6:0], 30'b0};
      dv_r_q    <= r_p;
      dv_neg_q  <= thd[THD_W-1];
      dv_sat_q  <= sat_p;
      dv_zero_q <= (r_p == '0);
      dx_dv_q   <= dx_p;
      dy_dv_q   <= dy_p;
    end
  end

  logic [QS_W-1:0]      q_s;
  logic [DV_SIDE_W-1:0] dv2_side;
  diff_t                dx_s, dy_s;
  logic                 neg_s, sat_s, zero_s;

  efd_div_pipe #(.DEN_W(R_W), .QUO_W(QS_W), .SIDE_W(DV_SIDE_W)) u_div_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vdv_q),
    .rem_i   (dv_rem_q),
    .low_i   (dv_low_q),
    .den_i   (dv_r_q),
    .side_i  ({dx_dv_q, dy_dv_q, dv_neg_q, dv_sat_q, dv_zero_q}),
    .valid_o (dv2_valid),
    .quo_o   (q_s),
    .side_o  (dv2_side)
  );

  assign {dx_s, dy_s, neg_s, sat_s, zero_s} = dv2_side;

  // Scale factor in Q.30; exactly one at zero radius.
  logic [QS_W-1:0]        q_c;
  logic signed [SC_W-1:0] q_sg;
  logic signed [SC_W-1:0] scale_q;
  diff_t                  dx_sc_q, dy_sc_q;

  assign q_c  = sat_s ? S_LIMIT : q_s;
  assign q_sg = $signed({2'b00, q_c});

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zero_s) begin
        scale_q <= ONE_Q30;
      end else if (neg_s) begin
        scale_q <= -q_sg;
      end else begin
        scale_q <= q_sg;
      end
      dx_sc_q <= dx_s;
      dy_sc_q <= dy_s;
    end
  end

  // Offset times scale, in two partial products per axis.
  logic signed [45:0] pxl_q, pxh_q, pyl_q, pyh_q;
  logic signed [19:0] sc_lo, sc_hi;
  assign sc_lo = $signed({1'b0, scale_q[18:0]});
  assign sc_hi = scale_q[38:19];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxl_q <= dx_sc_q * sc_lo;
      pxh_q <= dx_sc_q * sc_hi;
      pyl_q <= dy_sc_q * sc_lo;
      pyh_q <= dy_sc_q * sc_hi;
    end
  end

  // Round half up, add the centre back and saturate.
  logic signed [63:0] prod_x, prod_y, ox, oy;
  logic               clip_x, clip_y;
  logic signed [OUT_W-1:0] sx, sy;

  assign prod_x = ($signed(64'(pxh_q)) <<< 19) + 64'(pxl_q);
  assign prod_y = ($signed(64'(pyh_q)) <<< 19) + 64'(pyl_q);
  assign ox     = 64'(center_x_q) + ((prod_x + 64'sd536870912) >>> 30);
  assign oy     = 64'(center_y_q) + ((prod_y + 64'sd536870912) >>> 30);

  always_comb begin
    clip_x = 1'b1;
    clip_y = 1'b1;
    if (ox > OUT_MAX64) begin
      sx = OUT_MAX64[OUT_W-1:0];
    end else if (ox < OUT_MIN64) begin
      sx = OUT_MIN64[OUT_W-1:0];
    end else begin
      sx     = ox[OUT_W-1:0];
      clip_x = 1'b0;
    end
    if (oy > OUT_MAX64) begin
      sy = OUT_MAX64[OUT_W-1:0];
    end else if (oy < OUT_MIN64) begin
      sy = OUT_MIN64[OUT_W-1:0];
    end else begin
      sy     = oy[OUT_W-1:0];
      clip_y = 1'b0;
    end
  end

  logic signed [OUT_W-1:0] source_x_q, source_y_q;
  logic                    saturated_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      source_x_q  <= sx;
      source_y_q  <= sy;
      saturated_q <= clip_x || clip_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign source_x_o  = source_x_q;
  assign source_y_o  = source_y_q;
  assign saturated_o = saturated_q;

  // Both normalisation dividers must stay in lock step.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divx_valid == divy_valid)
    else $error("normalisation dividers out of step");

  // The scale factor never leaves its clamp.
  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vsc_q |-> (scale_q <= $signed({2'b00, S_LIMIT}) &&
               scale_q >= -$signed({2'b00, S_LIMIT})))
    else $error("scale factor out of range");

  // A clipped word carries at least one coordinate at a rail.
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (source_x_o == OUT_MAX64[OUT_W-1:0] || source_x_o == OUT_MIN64[OUT_W-1:0] ||
       source_y_o == OUT_MAX64[OUT_W-1:0] || source_y_o == OUT_MIN64[OUT_W-1:0]))
    else $error("saturation flag without a clipped coordinate");

endmodule

`default_nettype wire

>>> bench/equidistant_fisheye_distortion_map_tb.sv
// Testbench for the equidistant fisheye distortion map: directed and random
// pixels under several register settings, checked against a built-in predictor.
// Depends on efd_pkg and equidistant_fisheye_distortion_map.
`timescale 1ns / 1ps

module equidistant_fisheye_distortion_map_tb;
  import efd_pkg::*;

  localparam int CB = 12;
  localparam int ITER = 24;
  localparam int LATENCY = 135 + ITER;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [24:0] sx;
    logic signed [24:0] sy;
    logic               sat;
  } source_pos_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [CB-1:0] pix_col, pix_row;
  logic out_valid, out_ready;
  logic signed [OUT_W-1:0] src_x, src_y;
  logic sat;

  // Shadow copy of the configuration registers.
  logic [31:0] shadow_regs [8];
  source_pos_t expected_pos [$];
  int mismatches = 0, words_sent = 0, words_checked = 0;
  longint cycle_count = 0;

  equidistant_fisheye_distortion_map #(.COORD_BITS(CB), .ATAN_ITERATIONS(ITER)) u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pixel_column_i(pix_col), .pixel_row_i(pix_row), .out_valid_o(out_valid),
    .out_ready_i(out_ready), .source_x_o(src_x), .source_y_o(src_y),
    .saturated_o(sat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a generous limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint sign_ext(longint v, int w);
    longint m;
    m = (longint'(1) << w) - 1;
    v = v & m;
    if (v[w-1]) return v - (longint'(1) << w);
    return v;
  endfunction

  // Arithmetic shift right with flooring, safe for 128-bit products.
  function automatic logic signed [127:0] floor_shift(logic signed [127:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint normalise_offset(longint d, logic [23:0] f);
    logic [63:0] q, fd, md;
    fd = (f == 0) ? 64'd1 : {40'd0, f};
    md = (d < 0) ? -d : d;
    q = (md << 24) / fd;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip_coord(longint v, ref logic clipped);
    if (v > 64'sd16777215) begin
      clipped = 1'b1;
      return 64'sd16777215;
    end
    if (v < -64'sd16777216) begin
      clipped = 1'b1;
      return -64'sd16777216;
    end
    return v;
  endfunction

  // Distorted source position of one pixel under the current registers.
  function automatic source_pos_t distort_pixel(logic [CB-1:0] col, logic [CB-1:0] row);
    longint cx, cy, dx, dy, ix, iy, x, y, z, xs, ys, th, t2, t4, t6, t8, thd;
    longint scale, ox, oy;
    logic [63:0] a, b, r, q;
    logic signed [127:0] acc, poly, prod;
    int s;
    logic clipped;
    source_pos_t res;
    clipped = 1'b0;
    cx = sign_ext(shadow_regs[REG_CENTER_X], 25);
    cy = sign_ext(shadow_regs[REG_CENTER_Y], 25);
    dx = (longint'(col) << 8) - cx;
    dy = (longint'(row) << 8) - cy;
    ix = normalise_offset(dx, shadow_regs[REG_FOCAL_X][23:0]);
    iy = normalise_offset(dy, shadow_regs[REG_FOCAL_Y][23:0]);
    a = (ix < 0) ? -ix : ix;
    b = (iy < 0) ? -iy : iy;
    s = 0;
    while (s < 62 && (((a >> s) >> 31) != 0 || ((b >> s) >> 31) != 0)) s++;
    a = a >> s;
    b = b >> s;
    r = int_sqrt(a * a + b * b) << s;
    if (r == 0) begin
      scale = longint'(1) << 30;
    end else begin
      x = longint'(1) << 24;
      y = longint'(r);
      z = 0;
      for (int i = 0; i < ITER; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + longint'(atan_q30(i[4:0]));
        end else begin
          x = x - ys; y = y + xs; z = z - longint'(atan_q30(i[4:0]));
        end
      end
      if (z < 0) z = 0;
      if (z > 1686629713) z = 1686629713;
      th = z >>> 6;
      t2 = (th * th) >>> 24;
      t4 = (t2 * t2) >>> 24;
      t6 = (t4 * t2) >>> 24;
      t8 = (t4 * t4) >>> 24;
      acc = 128'(sign_ext(shadow_regs[REG_COEF_THETA2], 32)) * 128'(t2)
          + 128'(sign_ext(shadow_regs[REG_COEF_THETA4], 32)) * 128'(t4)
          + 128'(sign_ext(shadow_regs[REG_COEF_THETA6], 32)) * 128'(t6)
          + 128'(sign_ext(shadow_regs[REG_COEF_THETA8], 32)) * 128'(t8);
      poly = (128'sd1 <<< 30) + floor_shift(acc, 24);
      prod = floor_shift(128'(th) * poly, 30);
      thd = longint'(prod);
      q = ((thd < 0 ? -thd : thd) << 30) / r;
      if (q > (64'd1 << 37) - 1) q = (64'd1 << 37) - 1;
      scale = (thd < 0) ? -longint'(q) : longint'(q);
    end
    prod = floor_shift(128'(dx) * 128'(scale) + (128'sd1 <<< 29), 30);
    ox = clip_coord(cx + longint'(prod), clipped);
    prod = floor_shift(128'(dy) * 128'(scale) + (128'sd1 <<< 29), 30);
    oy = clip_coord(cy + longint'(prod), clipped);
    res.sx = ox[24:0];
    res.sy = oy[24:0];
    res.sat = clipped;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("Mismatch on word %0d: %s is %0d, expected %0d", words_checked, what, got, want);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] m;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= {1'b0, idx};
    cfg_data <= val;
    m = (idx <= REG_FOCAL_Y) ? 32'hFF_FFFF : (idx <= REG_CENTER_Y) ? 32'h1FF_FFFF : '1;
    shadow_regs[idx] = val & m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // An index beyond the register file must be ignored.
  task automatic write_bad_index(logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 4'd8 + 4'($urandom_range(0, 7));
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one word; valid stays up across back-to-back words.
  task automatic send_pixel(logic [CB-1:0] col, logic [CB-1:0] row, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pix_col <= col;
    pix_row <= row;
    expected_pos.push_back(distort_pixel(col, row));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pos.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Receiver stalls: a random hold per word, with calm stretches.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      source_pos_t want;
      if (expected_pos.size() == 0) begin
        mismatches++;
        $display("Unexpected word at cycle %0d", cycle_count);
      end else begin
        want = expected_pos.pop_front();
        if (src_x !== want.sx) report_mismatch("source_x", src_x, want.sx);
        if (src_y !== want.sy) report_mismatch("source_y", src_y, want.sy);
        if (sat !== want.sat) report_mismatch("saturated", sat, want.sat);
      end
      words_checked++;
    end
  end

  task automatic test_directed_reset_values();
    send_pixel(0, 0, 0);
    send_pixel('1, '1, 0);
    send_pixel(320, 240, 0);
    send_pixel(12'hAAA, 12'h555, 0);
    send_pixel(12'h555, 12'hAAA, 0);
    send_pixel(0, '1, 0);
    drain();
  endtask

  task automatic test_saturation_extremes();
    write_reg(REG_FOCAL_X, 32'd1);
    write_reg(REG_FOCAL_Y, 32'hFF_FFFF);
    write_reg(REG_CENTER_X, 32'h100_0000);
    write_reg(REG_CENTER_Y, 32'h0FF_FFFF);
    write_reg(REG_COEF_THETA2, 32'h7FFF_FFFF);
    write_reg(REG_COEF_THETA4, 32'h8000_0000);
    write_reg(REG_COEF_THETA6, 32'h7FFF_FFFF);
    write_reg(REG_COEF_THETA8, 32'h8000_0000);
    write_bad_index(32'h0);
    send_pixel(0, 0, 0);
    send_pixel('1, '1, 0);
    send_pixel(1, 4095, 0);
    drain();
    // Zero focal length acts as one.
    write_reg(REG_FOCAL_X, 32'd0);
    write_reg(REG_FOCAL_Y, 32'd0);
    send_pixel(100, 7, 0);
    send_pixel('1, 0, 0);
    drain();
  endtask

  task automatic test_zero_radius();
    write_reg(REG_FOCAL_X, 32'h10000);
    write_reg(REG_FOCAL_Y, 32'h10000);
    write_reg(REG_CENTER_X, 32'd64 << 8);
    write_reg(REG_CENTER_Y, 32'd48 << 8);
    write_reg(REG_COEF_THETA2, 32'hF000_0000);
    write_reg(REG_COEF_THETA4, 32'h0100_0000);
    write_reg(REG_COEF_THETA6, 32'h0);
    write_reg(REG_COEF_THETA8, 32'h0);
    send_pixel(64, 48, 0);
    send_pixel(65, 48, 0);
    send_pixel(64, 49, 0);
    send_pixel(0, 0, 0);
    drain();
  endtask

  task automatic randomise_regs(bit extreme);
    write_reg(REG_FOCAL_X, extreme ? $urandom : $urandom_range(32'h4000, 32'h80000));
    write_reg(REG_FOCAL_Y, extreme ? $urandom : $urandom_range(32'h4000, 32'h80000));
    write_reg(REG_CENTER_X, extreme ? $urandom : $urandom_range(0, 32'hF_FFFF));
    write_reg(REG_CENTER_Y, extreme ? $urandom : $urandom_range(0, 32'hF_FFFF));
    write_reg(REG_COEF_THETA2, extreme ? $urandom : 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000));
    write_reg(REG_COEF_THETA4, extreme ? $urandom : 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000));
    write_reg(REG_COEF_THETA6, extreme ? $urandom : 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000));
    write_reg(REG_COEF_THETA8, extreme ? $urandom : 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000));
  endtask

  task automatic test_random_pixels();
    for (int ph = 0; ph < 6; ph++) begin
      randomise_regs(ph >= 4);
      if (ph == 5) write_bad_index($urandom);
      for (int n = 0; n < 300; n++) begin
        // Mostly small coordinates near the centre, some anywhere.
        if ($urandom_range(0, 3) == 0)
          send_pixel(CB'($urandom), CB'($urandom), n % 100 >= 30);
        else
          send_pixel(CB'($urandom_range(0, 640)), CB'($urandom_range(0, 480)),
                     n % 100 >= 30);
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    pix_col = '0;
    pix_row = '0;
    shadow_regs[REG_FOCAL_X] = 131072;
    shadow_regs[REG_FOCAL_Y] = 131072;
    shadow_regs[REG_CENTER_X] = 81920;
    shadow_regs[REG_CENTER_Y] = 61440;
    for (int i = 4; i < 8; i++) shadow_regs[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_reset_values();
    test_saturation_extremes();
    test_zero_radius();
    test_random_pixels();
    $display("Sent %0d pixels and checked %0d source positions over 10 register settings.",
             words_sent, words_checked);
    if (mismatches == 0 && expected_pos.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words outstanding", mismatches, expected_pos.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> equidistant_fisheye_distortion_map.f
src/efd_pkg.sv
src/efd_div_pipe.sv
src/efd_isqrt_pipe.sv
src/efd_cordic_pipe.sv
src/efd_poly.sv
src/equidistant_fisheye_distortion_map.sv
bench/equidistant_fisheye_distortion_map_tb.sv
